// ===== hdl/velocity_reflect_keep_speed_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the velocity reflection block
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef VELOCITY_REFLECT_KEEP_SPEED_ASSERT_SVH
`define VELOCITY_REFLECT_KEEP_SPEED_ASSERT_SVH

`ifndef SYNTH
// check a property on every clock edge while out of reset
`define VRKS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check a property on every clock edge, reset included
`define VRKS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VRKS_ASSERT(lbl, clk, rst_n, prop, msg)
`define VRKS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hdl/vrks_pkg.sv =====
// ----------------------------------------------------------------------------
// vrks_pkg
// Stage counts, step types and per-bit step functions for the reflection
// pipeline.
// ----------------------------------------------------------------------------
package vrks_pkg;

  // square root iterations (one result bit each) and divider iterations
  localparam int unsigned NSQ  = 32;
  localparam int unsigned NDV  = 33;
  // 9 front stages, sqrt, product, numerator, divider, output register
  localparam int unsigned NSTG = NSQ + NDV + 12;

  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    logic [31:0] rem;
    logic        qbit;
  } dv_t;

  // one bit of a restoring square root: try root bit k
  function automatic sq_t sqrt_step(input logic [63:0] rem, input logic [31:0] root,
                                    input int unsigned k);
    logic [64:0] trial;
    sq_t         res;
    trial    = ({33'd0, root} << (k + 1)) | (65'd1 << (2 * k));
    res.rem  = rem;
    res.root = root;
    if ({1'b0, rem} >= trial) begin
      res.rem  = rem - trial[63:0];
      res.root = root | (32'd1 << k);
    end
    return res;
  endfunction

  // one bit of a restoring division: shift in a numerator bit, subtract
  function automatic dv_t div_step(input logic [31:0] rem, input logic nbit,
                                   input logic [31:0] den);
    logic [32:0] t;
    dv_t         res;
    t = {rem, nbit};
    if (t >= {1'b0, den}) begin
      res.rem  = 32'(t - {1'b0, den});
      res.qbit = 1'b1;
    end else begin
      res.rem  = t[31:0];
      res.qbit = 1'b0;
    end
    return res;
  endfunction

endpackage

// ===== hdl/vrks_if.sv =====
// ----------------------------------------------------------------------------
// vrks request channels
// Valid/ready channels for the normal/velocity request and the result.
// ----------------------------------------------------------------------------
interface vrks_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;

  modport source (output valid, normal_x, normal_y, normal_z, vel_x, vel_y, vel_z,
                  input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, vel_x, vel_y, vel_z,
                  output ready);
endinterface

interface vrks_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               degenerate;

  modport source (output valid, out_x, out_y, out_z, degenerate, input ready);
  modport sink   (input valid, out_x, out_y, out_z, degenerate, output ready);
endinterface

// ===== hdl/velocity_reflect_keep_speed.sv =====
// Pipeline: 77 register stages.
// Throughput: one request per cycle; the pipeline advances as a whole and
// holds every stage while the output register waits on out_o.ready.
// Depth is set by the 32-step square root and the 33-step divider.
// Reset: asynchronous, active low, clears the stage valid bits only.
// ----------------------------------------------------------------------------
// velocity_reflect_keep_speed
// Reflects a Q16.16 velocity about a Q2.14 normal and rescales the result to
// the incoming speed, saturating each component; a zero-length reflection gives zero.
// ----------------------------------------------------------------------------
`include "velocity_reflect_keep_speed_assert.svh"

module velocity_reflect_keep_speed (
  input  logic      clk_i,
  input  logic      rst_ni,
  vrks_in_if.sink   in_i,
  vrks_out_if.source out_o
);
  import vrks_pkg::*;

  logic            en;
  logic [NSTG-1:0] vld_q;

  // front stage registers
  logic signed [15:0] n1_q [3];
  logic signed [31:0] v1_q [3];
  logic        [63:0] sq2_q [3];
  logic signed [47:0] nv2_q [3];
  logic signed [15:0] n2_q [3];
  logic signed [31:0] v2_q [3];
  logic        [63:0] sumv3_q;
  logic signed [35:0] m16_3_q;
  logic signed [15:0] n3_q [3];
  logic signed [31:0] v3_q [3];
  logic signed [51:0] p4_q [3];
  logic signed [31:0] v4_q [3];
  logic        [63:0] sumv4_q;
  logic signed [41:0] r5_q [3];
  logic        [63:0] sumv5_q;
  logic        [40:0] mag6_q [3];
  logic        [2:0]  neg6_q;
  logic        [63:0] sumv6_q;
  logic        [30:0] a7_q [3];
  logic        [2:0]  neg7_q;
  logic        [63:0] sumv7_q;
  logic        [61:0] asq8_q [3];
  logic        [30:0] a8_q [3];
  logic        [2:0]  neg8_q;
  logic        [63:0] sumv8_q;

  // square root stages, index 0 loaded by the front end
  logic [63:0] sq_remv_q  [NSQ+1];
  logic [31:0] sq_rootv_q [NSQ+1];
  logic [63:0] sq_rema_q  [NSQ+1];
  logic [31:0] sq_roota_q [NSQ+1];
  logic [30:0] sq_a_q     [NSQ+1][3];
  logic [2:0]  sq_neg_q   [NSQ+1];

  // scaling product stage
  logic [62:0] prod_q [3];
  logic [31:0] len_q;
  logic [2:0]  pneg_q;

  // divider stages, index 0 loaded with the rounded numerator
  logic [63:0] dv_num_q [NDV+1][3];
  logic [31:0] dv_rem_q [NDV+1][3];
  logic [32:0] dv_quo_q [NDV+1][3];
  logic [31:0] dv_den_q [NDV+1];
  logic [2:0]  dv_neg_q [NDV+1];
  logic        dv_deg_q [NDV+1];

  logic signed [31:0] res_q [3];
  logic               deg_q;

  // advance the whole pipeline unless the output holds a stalled result
  assign en        = !vld_q[NSTG-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], in_i.valid};
    end
  end

  // capture the request
  always_ff @(posedge clk_i) begin
    if (en) begin
      n1_q[0] <= in_i.normal_x;
      n1_q[1] <= in_i.normal_y;
      n1_q[2] <= in_i.normal_z;
      v1_q[0] <= in_i.vel_x;
      v1_q[1] <= in_i.vel_y;
      v1_q[2] <= in_i.vel_z;
    end
  end

  // square the speed components, form the dot product terms
  always_ff @(posedge clk_i) begin
    logic [31:0] mv;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mv        = v1_q[i][31] ? (~v1_q[i] + 32'd1) : v1_q[i];
        sq2_q[i]  <= mv * mv;
        nv2_q[i]  <= n1_q[i] * v1_q[i];
        n2_q[i]   <= n1_q[i];
        v2_q[i]   <= v1_q[i];
      end
    end
  end

  // sum squares and round the dot product to Q16.16
  always_ff @(posedge clk_i) begin
    logic signed [49:0] m30;
    if (en) begin
      m30      = 50'(nv2_q[0]) + 50'(nv2_q[1]) + 50'(nv2_q[2]) + 50'sd8192;
      m16_3_q  <= m30[49:14];
      sumv3_q  <= sq2_q[0] + sq2_q[1] + sq2_q[2];
      n3_q     <= n2_q;
      v3_q     <= v2_q;
    end
  end

  // scale the normal by the dot product
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p4_q[i] <= m16_3_q * n3_q[i];
      end
      v4_q    <= v3_q;
      sumv4_q <= sumv3_q;
    end
  end

  // reflect and round back to Q16.16
  always_ff @(posedge clk_i) begin
    logic signed [55:0] t;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        t        = (56'(v4_q[i]) <<< 14) - (56'(p4_q[i]) <<< 1) + 56'sd8192;
        r5_q[i]  <= t[55:14];
      end
      sumv5_q <= sumv4_q;
    end
  end

  // split into sign and magnitude
  always_ff @(posedge clk_i) begin
    logic [41:0] m;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m          = r5_q[i][41] ? (~r5_q[i] + 42'd1) : r5_q[i];
        mag6_q[i]  <= m[40:0];
        neg6_q[i]  <= r5_q[i][41];
      end
      sumv6_q <= sumv5_q;
    end
  end

  // shift all magnitudes down until they fit in 31 bits
  always_ff @(posedge clk_i) begin
    logic [40:0] om;
    logic [3:0]  s;
    if (en) begin
      om = mag6_q[0] | mag6_q[1] | mag6_q[2];
      s  = 4'd0;
      for (int b = 31; b <= 40; b++) begin
        if (om[b]) s = 4'(b - 30);
      end
      for (int i = 0; i < 3; i++) begin
        a7_q[i] <= 31'(mag6_q[i] >> s);
      end
      neg7_q  <= neg6_q;
      sumv7_q <= sumv6_q;
    end
  end

  // square the reduced components
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        asq8_q[i] <= a7_q[i] * a7_q[i];
      end
      a8_q    <= a7_q;
      neg8_q  <= neg7_q;
      sumv8_q <= sumv7_q;
    end
  end

  // sum reduced squares, load both square roots
  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_remv_q[0]  <= sumv8_q;
      sq_rootv_q[0] <= '0;
      sq_rema_q[0]  <= 64'(asq8_q[0]) + 64'(asq8_q[1]) + 64'(asq8_q[2]);
      sq_roota_q[0] <= '0;
      sq_a_q[0]     <= a8_q;
      sq_neg_q[0]   <= neg8_q;
    end
  end

  // one root bit per stage for speed and reflected length
  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    sq_t stv, sta;
    always_comb begin
      stv = sqrt_step(sq_remv_q[j], sq_rootv_q[j], NSQ - 1 - j);
      sta = sqrt_step(sq_rema_q[j], sq_roota_q[j], NSQ - 1 - j);
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_remv_q[j+1]  <= stv.rem;
        sq_rootv_q[j+1] <= stv.root;
        sq_rema_q[j+1]  <= sta.rem;
        sq_roota_q[j+1] <= sta.root;
        sq_a_q[j+1]     <= sq_a_q[j];
        sq_neg_q[j+1]   <= sq_neg_q[j];
      end
    end
  end

  // multiply each component by the speed
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= sq_a_q[NSQ][i] * sq_rootv_q[NSQ];
      end
      len_q  <= sq_roota_q[NSQ];
      pneg_q <= sq_neg_q[NSQ];
    end
  end

  // add half the divisor for rounding, load the divider
  always_ff @(posedge clk_i) begin
    logic [63:0] num;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num             = 64'(prod_q[i]) + 64'(len_q >> 1);
        dv_num_q[0][i]  <= num;
        dv_rem_q[0][i]  <= {1'b0, num[63:33]};
        dv_quo_q[0][i]  <= '0;
      end
      dv_den_q[0] <= len_q;
      dv_neg_q[0] <= pneg_q;
      dv_deg_q[0] <= (len_q == '0);
    end
  end

  // one quotient bit per stage
  for (genvar j = 0; j < NDV; j++) begin : g_div
    dv_t st [3];
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        st[i] = div_step(dv_rem_q[j][i], dv_num_q[j][i][NDV-1-j], dv_den_q[j]);
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem_q[j+1][i] <= st[i].rem;
          dv_quo_q[j+1][i] <= dv_quo_q[j][i] | (33'(st[i].qbit) << (NDV - 1 - j));
          dv_num_q[j+1][i] <= dv_num_q[j][i];
        end
        dv_den_q[j+1] <= dv_den_q[j];
        dv_neg_q[j+1] <= dv_neg_q[j];
        dv_deg_q[j+1] <= dv_deg_q[j];
      end
    end
  end

  // restore sign, saturate, zero a degenerate result
  always_ff @(posedge clk_i) begin
    logic [32:0] q;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        q = dv_quo_q[NDV][i];
        if (dv_deg_q[NDV]) begin
          res_q[i] <= '0;
        end else if (dv_neg_q[NDV][i]) begin
          if (q > 33'h0_8000_0000) q = 33'h0_8000_0000;
          res_q[i] <= 32'(33'd0 - q);
        end else begin
          if (q > 33'h0_7FFF_FFFF) q = 33'h0_7FFF_FFFF;
          res_q[i] <= q[31:0];
        end
      end
      deg_q <= dv_deg_q[NDV];
    end
  end

  assign out_o.valid      = vld_q[NSTG-1];
  assign out_o.out_x      = res_q[0];
  assign out_o.out_y      = res_q[1];
  assign out_o.out_z      = res_q[2];
  assign out_o.degenerate = deg_q;

  // a degenerate result carries a zero vector
  `VRKS_ASSERT(a_deg_zero, clk_i, rst_ni, out_o.valid && out_o.degenerate |-> out_o.out_x == 0 && out_o.out_y == 0 && out_o.out_z == 0, "degenerate result is not zero")
  // a stalled result blocks new requests
  `VRKS_ASSERT(a_stall_blocks, clk_i, rst_ni, out_o.valid && !out_o.ready |-> !in_i.ready, "request taken during output stall")
  // no result is offered while in reset
  `VRKS_ASSERT_ALWAYS(a_rst_idle, clk_i, !rst_ni |=> !out_o.valid || !rst_ni, "result valid out of reset")

endmodule
